// ===== design/tbo_pkg.sv =====
// Package for the triangle/box overlap pipeline: field widths, internal
// arithmetic widths, beat structs and configuration register indexes.
// No dependencies.
`default_nettype none

package tbo_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int HALF_W  = COORD_W - 1;
    localparam int TAG_W   = 16;

    // Internal widths
    localparam int VW      = COORD_W + 1;      // vertex minus center
    localparam int FW      = COORD_W + 2;      // edge vector
    localparam int PROD_W  = VW + FW;          // v * f
    localparam int PW      = PROD_W + 1;       // edge projection
    localparam int RPROD_W = HALF_W + FW;      // h * |f|
    localparam int RW      = RPROD_W + 1;      // edge radius
    localparam int NPROD_W = 2 * FW;           // f0 * f1
    localparam int NW      = NPROD_W + 1;      // normal component
    localparam int SPL     = (NW + 1) / 2;     // split point of the normal
    localparam int NHW     = NW - SPL;         // upper part of the normal
    localparam int DLW     = SPL + 1 + VW;     // low partial of n * v
    localparam int DHW     = NHW + VW;         // high partial of n * v
    localparam int DSLW    = DLW + 2;
    localparam int DSHW    = DHW + 2;
    localparam int RLW     = HALF_W + SPL;     // h * low part of |n|
    localparam int RHW     = HALF_W + NHW;     // h * high part of |n|
    localparam int RSLW    = RLW + 2;
    localparam int RSHW    = RHW + 2;
    localparam int DW      = NW + VW + 2;      // plane distance and radius

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic        [TAG_W-1:0]   tri_tag;
    } tri_beat_t;

    typedef struct packed {
        logic             overlaps;
        logic [TAG_W-1:0] out_tag;
    } result_beat_t;

endpackage

`default_nettype wire

// ===== design/triangle_box_overlap.sv =====
// Triangle versus axis-aligned box overlap, separating axis test, 9 stages.
// Depends on tbo_pkg.
//
//  channel   dir  handshake              payload
//  s_        in   s_valid / s_ready      s_data   (tri_beat_t)
//  m_        out  m_valid / m_ready      m_data   (result_beat_t)
//  cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One triangle per cycle while the output is not stalled; m_valid rises once the
// beat has passed through stages 0 to 8, and the result beat is held until taken.
// Depth is set by the split normal-times-vertex products of the plane test.
// Each stage holds its beat until the next stage frees up, so bubbles close
// up behind a stalled output and nothing is dropped or repeated.
// aresetn (synchronous) clears valid bits and box registers; cfg_ready is
// always high.
`default_nettype none

module triangle_box_overlap
    import tbo_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tri_beat_t            s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output result_beat_t              m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);

    localparam int NSTG = 9;
    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    // Box registers
    logic signed [COORD_W-1:0] center_reg [3];
    logic        [HALF_W-1:0]  half_reg   [3];

    // Stage control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;
    logic [TAG_W-1:0] tag_reg [NSTG];

    // Stage 0: vertices relative to center
    logic signed [COORD_W-1:0] vert [3][3];
    logic signed [VW-1:0]      v0_reg [3][3];
    // Stage 1: edges
    logic signed [FW-1:0]      f1_reg [3][3];
    logic signed [VW-1:0]      v1_reg [3][3];
    // Stage 2: products, face test
    logic signed [PROD_W-1:0]  pa2_reg [3][3][3];
    logic signed [PROD_W-1:0]  pb2_reg [3][3][3];
    logic        [RPROD_W-1:0] ra2_reg [3][3];
    logic        [RPROD_W-1:0] rb2_reg [3][3];
    logic signed [NPROD_W-1:0] na2_reg [3];
    logic signed [NPROD_W-1:0] nb2_reg [3];
    logic signed [VW-1:0]      va2_reg [3];
    logic                      face2_reg;
    // Stage 3: projections, radii, normal
    logic signed [PW-1:0]      p3_reg [3][3][3];
    logic        [RW-1:0]      r3_reg [3][3];
    logic signed [NW-1:0]      n3_reg [3];
    logic signed [VW-1:0]      va3_reg [3];
    logic                      face3_reg;
    // Stage 4: projection bounds, plane partials
    logic signed [PW-1:0]      hi4_reg [3][3];
    logic signed [PW-1:0]      lo4_reg [3][3];
    logic        [RW-1:0]      r4_reg  [3][3];
    logic signed [DLW-1:0]     dl4_reg [3];
    logic signed [DHW-1:0]     dh4_reg [3];
    logic        [NW-1:0]      absn4_reg [3];
    logic                      face4_reg;
    // Stage 5: far distance, partial sums
    logic signed [PW:0]        far5_reg [3][3];
    logic        [RW-1:0]      r5_reg   [3][3];
    logic signed [DSLW-1:0]    dsl5_reg;
    logic signed [DSHW-1:0]    dsh5_reg;
    logic        [RLW-1:0]     rl5_reg [3];
    logic        [RHW-1:0]     rh5_reg [3];
    logic                      face5_reg;
    // Stage 6: edge verdict, plane distance
    logic                      sep6_reg;
    logic signed [DW-1:0]      d6_reg;
    logic        [RSLW-1:0]    rsl6_reg;
    logic        [RSHW-1:0]    rsh6_reg;
    // Stage 7: magnitudes
    logic                      sep7_reg;
    logic        [DW-1:0]      absd7_reg;
    logic        [DW-1:0]      rad7_reg;
    // Stage 8: output
    logic                      ovl_reg;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                center_reg[k] <= '0;
                half_reg[k]   <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_HALF_X:   half_reg[0]   <= cfg_data[HALF_W-1:0];
                CFG_HALF_Y:   half_reg[1]   <= cfg_data[HALF_W-1:0];
                CFG_HALF_Z:   half_reg[2]   <= cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Stall chain: a stage loads when empty or when its successor loads
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NSTG-1];
    assign m_data  = '{overlaps: ovl_reg, out_tag: tag_reg[NSTG-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tag_reg[0] <= s_data.tri_tag;
        end
        for (int s = 1; s < NSTG; s++) begin
            if (en[s]) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // Stage 0: subtract box center
    always_comb begin
        vert[0][0] = s_data.a_x; vert[0][1] = s_data.a_y; vert[0][2] = s_data.a_z;
        vert[1][0] = s_data.b_x; vert[1][1] = s_data.b_y; vert[1][2] = s_data.b_z;
        vert[2][0] = s_data.c_x; vert[2][1] = s_data.c_y; vert[2][2] = s_data.c_z;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int t = 0; t < 3; t++) begin
                for (int k = 0; k < 3; k++) begin
                    v0_reg[t][k] <= VW'(vert[t][k]) - VW'(center_reg[k]);
                end
            end
        end
    end

    // Stage 1: edge vectors
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    f1_reg[e][k] <= FW'(v0_reg[(e + 1) % 3][k]) - FW'(v0_reg[e][k]);
                    v1_reg[e][k] <= v0_reg[e][k];
                end
            end
        end
    end

    // Stage 2: cross-axis products, radius products, normal products, face test
    logic [FW-1:0]        absf [3][3];
    logic signed [VW-1:0] fhi  [3];
    logic signed [VW-1:0] flo  [3];
    logic signed [VW:0]   ffar [3];
    logic [2:0]           fsep;

    always_comb begin
        for (int e = 0; e < 3; e++) begin
            for (int k = 0; k < 3; k++) begin
                absf[e][k] = f1_reg[e][k][FW-1] ? FW'(-f1_reg[e][k]) : FW'(f1_reg[e][k]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            fhi[k] = v1_reg[0][k];
            flo[k] = v1_reg[0][k];
            for (int t = 1; t < 3; t++) begin
                if (v1_reg[t][k] > fhi[k]) fhi[k] = v1_reg[t][k];
                if (v1_reg[t][k] < flo[k]) flo[k] = v1_reg[t][k];
            end
            ffar[k] = (-(VW + 1)'(fhi[k]) > (VW + 1)'(flo[k])) ?
                      -(VW + 1)'(fhi[k]) : (VW + 1)'(flo[k]);
            fsep[k] = ffar[k] > $signed((VW + 1)'(half_reg[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int k = 0; k < 3; k++) begin
                for (int e = 0; e < 3; e++) begin
                    for (int t = 0; t < 3; t++) begin
                        pa2_reg[k][e][t] <= PROD_W'(v1_reg[t][NXT2[k]])
                                            * PROD_W'(f1_reg[e][NXT1[k]]);
                        pb2_reg[k][e][t] <= PROD_W'(v1_reg[t][NXT1[k]])
                                            * PROD_W'(f1_reg[e][NXT2[k]]);
                    end
                    ra2_reg[k][e] <= RPROD_W'(half_reg[NXT1[k]]) * RPROD_W'(absf[e][NXT2[k]]);
                    rb2_reg[k][e] <= RPROD_W'(half_reg[NXT2[k]]) * RPROD_W'(absf[e][NXT1[k]]);
                end
                na2_reg[k] <= NPROD_W'(f1_reg[0][NXT1[k]]) * NPROD_W'(f1_reg[1][NXT2[k]]);
                nb2_reg[k] <= NPROD_W'(f1_reg[0][NXT2[k]]) * NPROD_W'(f1_reg[1][NXT1[k]]);
                va2_reg[k] <= v1_reg[0][k];
            end
            face2_reg <= |fsep;
        end
    end

    // Stage 3: projections, radii, triangle normal
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int k = 0; k < 3; k++) begin
                for (int e = 0; e < 3; e++) begin
                    for (int t = 0; t < 3; t++) begin
                        p3_reg[k][e][t] <= PW'(pa2_reg[k][e][t]) - PW'(pb2_reg[k][e][t]);
                    end
                    r3_reg[k][e] <= RW'(ra2_reg[k][e]) + RW'(rb2_reg[k][e]);
                end
                n3_reg[k]  <= NW'(na2_reg[k]) - NW'(nb2_reg[k]);
                va3_reg[k] <= va2_reg[k];
            end
            face3_reg <= face2_reg;
        end
    end

    // Stage 4: projection bounds; normal split into halves for the plane products
    logic signed [PW-1:0] phi [3][3];
    logic signed [PW-1:0] plo [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int e = 0; e < 3; e++) begin
                phi[k][e] = p3_reg[k][e][0];
                plo[k][e] = p3_reg[k][e][0];
                for (int t = 1; t < 3; t++) begin
                    if (p3_reg[k][e][t] > phi[k][e]) phi[k][e] = p3_reg[k][e][t];
                    if (p3_reg[k][e][t] < plo[k][e]) plo[k][e] = p3_reg[k][e][t];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                for (int e = 0; e < 3; e++) begin
                    hi4_reg[k][e] <= phi[k][e];
                    lo4_reg[k][e] <= plo[k][e];
                    r4_reg[k][e]  <= r3_reg[k][e];
                end
                dl4_reg[k] <= DLW'($signed({1'b0, n3_reg[k][SPL-1:0]})) * DLW'(va3_reg[k]);
                dh4_reg[k] <= DHW'($signed(n3_reg[k][NW-1:SPL])) * DHW'(va3_reg[k]);
                absn4_reg[k] <= n3_reg[k][NW-1] ? NW'(-n3_reg[k]) : NW'(n3_reg[k]);
            end
            face4_reg <= face3_reg;
        end
    end

    // Stage 5: far side of each projection; plane partial sums and radius products
    logic signed [PW:0] nhi [3][3];
    logic signed [PW:0] elo [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int e = 0; e < 3; e++) begin
                nhi[k][e] = -(PW + 1)'(hi4_reg[k][e]);
                elo[k][e] = (PW + 1)'(lo4_reg[k][e]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int k = 0; k < 3; k++) begin
                for (int e = 0; e < 3; e++) begin
                    far5_reg[k][e] <= (nhi[k][e] > elo[k][e]) ? nhi[k][e] : elo[k][e];
                    r5_reg[k][e]   <= r4_reg[k][e];
                end
                rl5_reg[k] <= RLW'(half_reg[k]) * RLW'(absn4_reg[k][SPL-1:0]);
                rh5_reg[k] <= RHW'(half_reg[k]) * RHW'(absn4_reg[k][NW-1:SPL]);
            end
            dsl5_reg  <= DSLW'(dl4_reg[0]) + DSLW'(dl4_reg[1]) + DSLW'(dl4_reg[2]);
            dsh5_reg  <= DSHW'(dh4_reg[0]) + DSHW'(dh4_reg[1]) + DSHW'(dh4_reg[2]);
            face5_reg <= face4_reg;
        end
    end

    // Stage 6: edge-axis verdict; plane distance and radius partial sums
    logic [8:0] esep;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int e = 0; e < 3; e++) begin
                esep[k * 3 + e] = (PW + 2)'(far5_reg[k][e])
                                  > $signed((PW + 2)'(r5_reg[k][e]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            sep6_reg <= face5_reg || (|esep);
            d6_reg   <= (DW'(dsh5_reg) <<< SPL) + DW'(dsl5_reg);
            rsl6_reg <= RSLW'(rl5_reg[0]) + RSLW'(rl5_reg[1]) + RSLW'(rl5_reg[2]);
            rsh6_reg <= RSHW'(rh5_reg[0]) + RSHW'(rh5_reg[1]) + RSHW'(rh5_reg[2]);
        end
    end

    // Stage 7: plane distance magnitude and box radius along the normal
    always_ff @(posedge aclk) begin
        if (en[7]) begin
            sep7_reg  <= sep6_reg;
            absd7_reg <= d6_reg[DW-1] ? DW'(-d6_reg) : DW'(d6_reg);
            rad7_reg  <= (DW'(rsh6_reg) << SPL) + DW'(rsl6_reg);
        end
    end

    // Stage 8: plane verdict and result
    always_ff @(posedge aclk) begin
        if (en[8]) begin
            ovl_reg <= !(sep7_reg || (rad7_reg < absd7_reg));
        end
    end

endmodule

`default_nettype wire

// ===== design/tbo_checker.sv =====
// Port-level checks for triangle_box_overlap, attached by bind.
// Depends on tbo_pkg.
`default_nettype none

module tbo_checker
    import tbo_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_ready,
    input wire logic         m_valid,
    input wire logic         m_ready,
    input wire result_beat_t m_data,
    input wire logic         cfg_ready
);

    // Nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // An empty output stage means the whole pipe can take a beat
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // Config port never back-pressures
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind triangle_box_overlap tbo_checker u_tbo_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== sim/tb_triangle_box_overlap.sv =====
// Self-checking bench for triangle_box_overlap: separating-axis overlap of
// streamed triangles against the configured box. Depends on tbo_pkg and the DUT.
`timescale 1ns / 1ps

module tb_triangle_box_overlap;
    import tbo_pkg::*;

    localparam int WD_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tri_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    result_beat_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;

    triangle_box_overlap i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // box as seen by the predictor
    logic signed [COORD_W-1:0] box_ctr[3];
    logic [HALF_W-1:0] box_half[3];

    tri_beat_t tri_q[$];
    result_beat_t overlap_q[$];
    int n_err = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_off = 0;
    logic drain_pause = 1'b0;
    int idle_cycles = 0;
    int stall_mode = 0;

    function automatic logic signed [127:0] mag(logic signed [127:0] x);
        return x < 0 ? -x : x;
    endfunction

    // true if all projections lie strictly above r or all lie strictly below -r
    function automatic bit apart(logic signed [127:0] p0, logic signed [127:0] p1,
                                 logic signed [127:0] p2, logic signed [127:0] r);
        logic signed [127:0] hi, lo;
        hi = p0; lo = p0;
        if (p1 > hi) hi = p1;
        if (p2 > hi) hi = p2;
        if (p1 < lo) lo = p1;
        if (p2 < lo) lo = p2;
        return (lo > r) || (-hi > r);
    endfunction

    function automatic result_beat_t box_overlap(tri_beat_t t);
        logic signed [127:0] v[3][3], f[3][3], h[3], nrm[3], p[3], r, d;
        logic signed [127:0] vin[9];
        result_beat_t res;
        bit sep;
        int i, j;
        sep = 0;
        vin = '{t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z};
        for (int k = 0; k < 3; k++) h[k] = {105'd0, box_half[k]};
        for (int q = 0; q < 3; q++)
            for (int k = 0; k < 3; k++)
                v[q][k] = vin[q*3+k] - 128'(box_ctr[k]);
        for (int e = 0; e < 3; e++)
            for (int k = 0; k < 3; k++)
                f[e][k] = v[(e+1)%3][k] - v[e][k];
        // edge x box axis
        for (int k = 0; k < 3; k++) begin
            i = (k + 1) % 3; j = (k + 2) % 3;
            for (int e = 0; e < 3; e++) begin
                for (int q = 0; q < 3; q++) p[q] = v[q][j]*f[e][i] - v[q][i]*f[e][j];
                r = h[i]*mag(f[e][j]) + h[j]*mag(f[e][i]);
                if (apart(p[0], p[1], p[2], r)) sep = 1;
            end
        end
        // box faces
        for (int k = 0; k < 3; k++)
            if (apart(v[0][k], v[1][k], v[2][k], h[k])) sep = 1;
        // triangle plane
        for (int k = 0; k < 3; k++) begin
            i = (k + 1) % 3; j = (k + 2) % 3;
            nrm[k] = f[0][i]*f[1][j] - f[0][j]*f[1][i];
        end
        d = nrm[0]*v[0][0] + nrm[1]*v[0][1] + nrm[2]*v[0][2];
        r = h[0]*mag(nrm[0]) + h[1]*mag(nrm[1]) + h[2]*mag(nrm[2]);
        if (mag(d) > r) sep = 1;
        res.overlaps = !sep;
        res.out_tag = t.tri_tag;
        return res;
    endfunction

    // sender: bursts and gaps, optional drain pause
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            automatic bit take = s_valid && s_ready;
            automatic bit go;
            if (take) begin
                overlap_q.push_back(box_overlap(s_data));
                void'(tri_q.pop_front());
                if (burst_left > 0) burst_left--;
            end
            if (s_valid && !take) begin
                // hold the beat
            end else begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                if (hold_off > 0) begin
                    hold_off--;
                    go = 0;
                end else if (drain_pause) begin
                    go = 0;
                end else if (gap_left > 0 && burst_left == 0) begin
                    gap_left--;
                    go = 0;
                end else begin
                    go = (tri_q.size() > 0) && (burst_left > 0);
                    if (burst_left == 0 && gap_left == 0) go = 0;
                end
                s_valid <= go;
                if (go) s_data <= tri_q[0];
            end
        end
    end

    // receiver stall pattern and result check
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (overlap_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result beat tag %0h", m_data.out_tag);
                end else begin
                    automatic result_beat_t exp_r = overlap_q.pop_front();
                    if (m_data.overlaps !== exp_r.overlaps ||
                        m_data.out_tag !== exp_r.out_tag) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp overlaps=%0b tag=%0h got overlaps=%0b tag=%0h",
                                     exp_r.overlaps, exp_r.out_tag,
                                     m_data.overlaps, m_data.out_tag);
                    end
                end
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
        end
    end

    // watchdog: cycles with no beat accepted
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || (tri_q.size() == 0 && overlap_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] rnd_coord(int scale);
        case (scale)
            0: return COORD_W'($signed($urandom_range(0, 4000)) - 2000);
            1: return COORD_W'($signed($urandom_range(0, 200000)) - 100000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic tri_beat_t make_tri(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
        logic [COORD_W-1:0] az, logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
        logic [COORD_W-1:0] bz, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
        logic [COORD_W-1:0] cz);
        tri_beat_t t;
        t = '{ax, ay, az, bx, by, bz, cx, cy, cz, TAG_W'($urandom)};
        return t;
    endfunction

    // near the box center, with spread set by scale; scale 2 gives fully random vertices
    function automatic tri_beat_t rnd_tri(int scale);
        logic [COORD_W-1:0] c[9];
        for (int k = 0; k < 9; k++)
            c[k] = (scale == 2) ? rnd_coord(2) : box_ctr[k%3] + rnd_coord(scale);
        return make_tri(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= CFG_CENTER_Z) box_ctr[idx] = val;
        else box_half[idx - CFG_HALF_X] = val[HALF_W-1:0];
    endtask

    task automatic set_box(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                           logic [COORD_W-1:0] cz, logic [COORD_W-1:0] hx,
                           logic [COORD_W-1:0] hy, logic [COORD_W-1:0] hz);
        // all beats out, then the pipeline's latency before touching registers
        wait (tri_q.size() == 0 && !s_valid && overlap_q.size() == 0);
        repeat (12) @(posedge aclk);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_HALF_X, hx);
        write_reg(CFG_HALF_Y, hy);
        write_reg(CFG_HALF_Z, hz);
    endtask

    localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] HMAX = {1'b0, {(COORD_W-1){1'b1}}};

    initial begin
        int scale;
        for (int k = 0; k < 3; k++) begin
            box_ctr[k] = '0;
            box_half[k] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: point box at origin (reset registers)
        tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        tri_q.push_back(make_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, 0));
        set_box(0, 0, 0, 256, 256, 256);
        // touching face, touching edge, plane grazing corner, degenerate, far
        tri_q.push_back(make_tri(256, 0, 0, 256, 100, 0, 256, 0, 100));
        tri_q.push_back(make_tri(257, 0, 0, 257, 100, 0, 257, 0, 100));
        tri_q.push_back(make_tri(512, 0, 0, 0, 512, 0, 0, 0, 512));
        tri_q.push_back(make_tri(768, 0, 0, 0, 768, 0, 0, 0, 768));
        tri_q.push_back(make_tri(769, 0, 0, 0, 769, 0, 0, 0, 769));
        tri_q.push_back(make_tri(-1000, 0, 0, 0, 0, 0, 1000, 0, 0));
        tri_q.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
        tri_q.push_back(make_tri(300, 300, 0, 300, 300, 0, 300, 300, 0));
        tri_q.push_back(make_tri(-300, 260, 0, 260, -300, 0, 600, 600, 0));
        tri_q.push_back(make_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX));
        set_box(CMAX, CMIN, CMAX, HMAX, HMAX, HMAX);
        tri_q.push_back(make_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN));
        tri_q.push_back(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        tri_q.push_back(make_tri(CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
        set_box(CMIN, CMAX, CMIN, 0, HMAX, 0);
        tri_q.push_back(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX));
        tri_q.push_back(make_tri(CMIN, 0, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN));
        tri_q.push_back(make_tri(CMAX, 0, CMIN, CMIN, CMAX, CMIN, CMIN, 5, CMAX));

        // random phases with a range of boxes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: set_box(rnd_coord(1), rnd_coord(1), rnd_coord(1),
                           COORD_W'($urandom_range(0, 3000)),
                           COORD_W'($urandom_range(0, 3000)),
                           COORD_W'($urandom_range(0, 3000)));
                1: set_box(rnd_coord(2), rnd_coord(2), rnd_coord(2),
                           COORD_W'($urandom) & HMAX, COORD_W'($urandom) & HMAX,
                           COORD_W'($urandom) & HMAX);
                2: set_box(rnd_coord(0), rnd_coord(0), rnd_coord(0), 0, 0, 0);
                default: set_box(rnd_coord(1), rnd_coord(1), rnd_coord(1),
                                 COORD_W'($urandom_range(0, 60000)),
                                 COORD_W'($urandom_range(0, 60000)),
                                 COORD_W'($urandom_range(0, 60000)));
            endcase
            for (int n = 0; n < 80; n++) begin
                scale = $urandom_range(0, 9);
                if (ph % 4 == 1) scale = (scale < 5) ? 2 : 1;
                else scale = (scale < 6) ? 0 : (scale < 9 ? 1 : 2);
                if (ph % 4 == 3 && scale == 0) scale = 1;
                tri_q.push_back(rnd_tri(scale));
            end
            // sender waits for the pipeline to empty mid-phase once
            if (ph == 3) begin
                wait (tri_q.size() < 40);
                drain_pause = 1'b1;
                wait (overlap_q.size() == 0 && !s_valid);
                drain_pause = 1'b0;
            end
        end

        wait (tri_q.size() == 0 && !s_valid && overlap_q.size() == 0);
        repeat (30) @(posedge aclk);
        if (n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tbo_pkg.sv
design/triangle_box_overlap.sv
design/tbo_checker.sv
sim/tb_triangle_box_overlap.sv
